// ===== hdl/rlzz_pkg.sv =====
// shared types, constants and microcode definitions for the run-length zigzag decoder
package rlzz_pkg;

   localparam int DEF_BLOCK_SIDE     = 8;
   localparam int DEF_COUNT_BITS     = 6;
   localparam int DEF_MAGNITUDE_BITS = 10;

   localparam int BYTE_W     = 8;
   localparam int BITS_W     = 4;
   localparam int POS_OUT_W  = 3;
   localparam int COEF_W     = 11;
   localparam int AVG_W      = 8;
   localparam int PAYLOAD_W  = 2 * POS_OUT_W + COEF_W + AVG_W;
   localparam int RSP_DATA_W = 32;

   typedef logic [1:0] step_type;

   localparam step_type STEP_FETCH = 2'd0;
   localparam step_type STEP_BIT   = 2'd1;
   localparam step_type STEP_EMIT  = 2'd2;
   localparam step_type STEP_FLUSH = 2'd3;

   typedef enum logic [1:0] {
      OP_FETCH,
      OP_BIT,
      OP_EMIT,
      OP_FLUSH
   } op_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_PHASE_AVG,
      COND_REC_DONE,
      COND_LAST_BIT,
      COND_EMIT_MORE,
      COND_RUN_EXIT
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond_a;
      step_type target_a;
      cond_type cond_b;
      step_type target_b;
      step_type next;
   } ucode_type;

   typedef struct packed {
      logic req_valid;
      logic slot_free;
      logic pend_valid;
      logic emit_more;
      logic phase_avg;
      logic rec_done;
      logic last_bit;
      logic run_exit;
   } flags_type;

   typedef struct packed {
      op_type op;
      logic   fire;
   } ctrl_type;

endpackage

// ===== hdl/rlzz_seq.sv =====
// microcode sequencer: program table, step counter and conditional jumps
module rlzz_seq (
   input  logic                clock,
   input  logic                reset,
   input  rlzz_pkg::flags_type flags,
   output rlzz_pkg::ctrl_type  ctrl
);

   rlzz_pkg::step_type  step_ff;
   rlzz_pkg::step_type  step_in;
   rlzz_pkg::ucode_type word;
   logic                go;

   function automatic rlzz_pkg::ucode_type rom(input rlzz_pkg::step_type s);
      rlzz_pkg::ucode_type w;
      unique case (s)
         rlzz_pkg::STEP_FETCH: w = '{rlzz_pkg::OP_FETCH,
                                     rlzz_pkg::COND_PHASE_AVG, rlzz_pkg::STEP_FETCH,
                                     rlzz_pkg::COND_NONE, rlzz_pkg::STEP_FETCH,
                                     rlzz_pkg::STEP_BIT};
         rlzz_pkg::STEP_BIT:   w = '{rlzz_pkg::OP_BIT,
                                     rlzz_pkg::COND_REC_DONE, rlzz_pkg::STEP_EMIT,
                                     rlzz_pkg::COND_LAST_BIT, rlzz_pkg::STEP_FLUSH,
                                     rlzz_pkg::STEP_BIT};
         rlzz_pkg::STEP_EMIT:  w = '{rlzz_pkg::OP_EMIT,
                                     rlzz_pkg::COND_EMIT_MORE, rlzz_pkg::STEP_EMIT,
                                     rlzz_pkg::COND_RUN_EXIT, rlzz_pkg::STEP_FLUSH,
                                     rlzz_pkg::STEP_BIT};
         default:              w = '{rlzz_pkg::OP_FLUSH,
                                     rlzz_pkg::COND_NONE, rlzz_pkg::STEP_FETCH,
                                     rlzz_pkg::COND_NONE, rlzz_pkg::STEP_FETCH,
                                     rlzz_pkg::STEP_FETCH};
      endcase
      return w;
   endfunction

   function automatic logic test(input rlzz_pkg::cond_type c, input rlzz_pkg::flags_type f);
      logic r;
      unique case (c)
         rlzz_pkg::COND_PHASE_AVG: r = f.phase_avg;
         rlzz_pkg::COND_REC_DONE:  r = f.rec_done;
         rlzz_pkg::COND_LAST_BIT:  r = f.last_bit;
         rlzz_pkg::COND_EMIT_MORE: r = f.emit_more;
         rlzz_pkg::COND_RUN_EXIT:  r = f.run_exit;
         default:                  r = 1'b0;
      endcase
      return r;
   endfunction

   assign word = rom(step_ff);

   always_comb begin
      unique case (word.op)
         rlzz_pkg::OP_FETCH: go = flags.req_valid;
         rlzz_pkg::OP_BIT:   go = 1'b1;
         rlzz_pkg::OP_EMIT:  go = !flags.emit_more || flags.slot_free;
         default:            go = !flags.pend_valid || flags.slot_free;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (go) begin
         if (test(word.cond_a, flags)) begin
            step_in = word.target_a;
         end else if (test(word.cond_b, flags)) begin
            step_in = word.target_b;
         end else begin
            step_in = word.next;
         end
      end
   end

   assign ctrl.op   = word.op;
   assign ctrl.fire = go;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= rlzz_pkg::STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== hdl/run_length_zigzag_block_decoder.sv =====
// run-length zigzag block decoder: bit parser datapath, result staging and output register
// average byte: a fetch step; other bytes: fetch, bit steps and flush, less at block end
// plus, per completed record, an emit step per emitted coefficient and a closing emit step
// the rate is set by the one-bit-per-step parse loop and the emit loop, which gives one result
// per cycle unless the output stalls; each result is staged, then registered at the output
// synchronous active-high reset clears the sequencer, parse state, pending and output valid
module run_length_zigzag_block_decoder #(
   parameter int BLOCK_SIDE     = rlzz_pkg::DEF_BLOCK_SIDE,
   parameter int COUNT_BITS     = rlzz_pkg::DEF_COUNT_BITS,
   parameter int MAGNITUDE_BITS = rlzz_pkg::DEF_MAGNITUDE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rlzz_pkg::BYTE_W-1:0]     req_tdata,  // stream_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rlzz_pkg::RSP_DATA_W-1:0] rsp_tdata,  // row, column, coefficient, block_average
   output logic                            rsp_tlast,  // last_in_block
   output logic                            rsp_tuser   // last_of_burst
);

   localparam int COUNT   = BLOCK_SIDE * BLOCK_SIDE;
   localparam int SCAN_W  = $clog2(COUNT + 1);
   localparam int POS_W   = $clog2(BLOCK_SIDE);
   localparam int RUN_W   = COUNT_BITS + 1;
   localparam int FIELD_W = (COUNT_BITS > MAGNITUDE_BITS) ? COUNT_BITS : MAGNITUDE_BITS;
   localparam int LEFT_W  = $clog2(FIELD_W + 1);
   localparam int NEG_W   = (MAGNITUDE_BITS > rlzz_pkg::COEF_W) ? MAGNITUDE_BITS
                                                                : rlzz_pkg::COEF_W;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(BLOCK_SIDE - 1);

   typedef enum logic [1:0] {
      PH_AVERAGE,
      PH_SIGN,
      PH_COUNT,
      PH_MAG
   } phase_type;

   rlzz_pkg::flags_type flags;
   rlzz_pkg::ctrl_type  ctrl;

   phase_type                         phase_ff, phase_in;
   logic [rlzz_pkg::BITS_W-1:0]       bits_ff, bits_in;
   logic [rlzz_pkg::BYTE_W-1:0]       shift_ff, shift_in;
   logic [LEFT_W-1:0]                 left_ff, left_in;
   logic [FIELD_W-1:0]                field_ff, field_in;
   logic                              sign_ff, sign_in;
   logic [RUN_W-1:0]                  run_len_ff, run_len_in;
   logic [RUN_W-1:0]                  run_left_ff, run_left_in;
   logic [rlzz_pkg::COEF_W-1:0]       coef_ff, coef_in;
   logic [SCAN_W-1:0]                 scan_ff, scan_in;
   logic [POS_W-1:0]                  row_ff, row_in;
   logic [POS_W-1:0]                  col_ff, col_in;
   logic [rlzz_pkg::AVG_W-1:0]        avg_ff, avg_in;
   logic                              pend_valid_ff, pend_valid_in;
   logic [rlzz_pkg::PAYLOAD_W-1:0]    pend_data_ff, pend_data_in;
   logic                              pend_last_ff, pend_last_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rlzz_pkg::PAYLOAD_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              rsp_user_ff, rsp_user_in;

   logic                              bit_in;
   logic [FIELD_W-1:0]                field_new;
   logic [NEG_W-1:0]                  mag_ext;
   logic [NEG_W-1:0]                  mag_neg;
   logic                              slot_free;
   logic                              emit_more;
   logic                              going_up;

   assign bit_in    = shift_ff[rlzz_pkg::BYTE_W-1];
   assign field_new = {field_ff[FIELD_W-2:0], bit_in};
   assign mag_ext   = NEG_W'(field_new[MAGNITUDE_BITS-1:0]);
   assign mag_neg   = '0 - mag_ext;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign emit_more = (run_left_ff != '0) && (scan_ff < SCAN_W'(COUNT));
   assign going_up  = !(row_ff[0] ^ col_ff[0]);

   assign flags.req_valid  = req_tvalid;
   assign flags.slot_free  = slot_free;
   assign flags.pend_valid = pend_valid_ff;
   assign flags.emit_more  = emit_more;
   assign flags.phase_avg  = (phase_ff == PH_AVERAGE);
   assign flags.rec_done   = (phase_ff == PH_MAG) && (left_ff == LEFT_W'(1));
   assign flags.last_bit   = (bits_ff == rlzz_pkg::BITS_W'(1));
   assign flags.run_exit   = (bits_ff == '0) || (scan_ff >= SCAN_W'(COUNT));

   rlzz_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   always_comb begin
      phase_in      = phase_ff;
      bits_in       = bits_ff;
      shift_in      = shift_ff;
      left_in       = left_ff;
      field_in      = field_ff;
      sign_in       = sign_ff;
      run_len_in    = run_len_ff;
      run_left_in   = run_left_ff;
      coef_in       = coef_ff;
      scan_in       = scan_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      avg_in        = avg_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      pend_last_in  = pend_last_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_user_in   = rsp_user_ff;

      if (ctrl.fire) begin
         unique case (ctrl.op)
            rlzz_pkg::OP_FETCH: begin
               if (phase_ff == PH_AVERAGE) begin
                  avg_in   = req_tdata;
                  scan_in  = '0;
                  row_in   = '0;
                  col_in   = '0;
                  phase_in = PH_SIGN;
               end else begin
                  shift_in = req_tdata;
                  bits_in  = rlzz_pkg::BITS_W'(rlzz_pkg::BYTE_W);
               end
            end
            rlzz_pkg::OP_BIT: begin
               shift_in = {shift_ff[rlzz_pkg::BYTE_W-2:0], 1'b0};
               bits_in  = bits_ff - rlzz_pkg::BITS_W'(1);
               unique case (phase_ff)
                  PH_SIGN: begin
                     sign_in  = bit_in;
                     left_in  = LEFT_W'(COUNT_BITS);
                     field_in = '0;
                     phase_in = PH_COUNT;
                  end
                  PH_COUNT: begin
                     field_in = field_new;
                     left_in  = left_ff - LEFT_W'(1);
                     if (left_ff == LEFT_W'(1)) begin
                        run_len_in = RUN_W'(field_new[COUNT_BITS-1:0]) + RUN_W'(1);
                        left_in    = LEFT_W'(MAGNITUDE_BITS);
                        field_in   = '0;
                        phase_in   = PH_MAG;
                     end
                  end
                  PH_MAG: begin
                     field_in = field_new;
                     left_in  = left_ff - LEFT_W'(1);
                     if (left_ff == LEFT_W'(1)) begin
                        coef_in     = sign_ff ? mag_neg[rlzz_pkg::COEF_W-1:0]
                                              : mag_ext[rlzz_pkg::COEF_W-1:0];
                        run_left_in = run_len_ff;
                        field_in    = '0;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
            rlzz_pkg::OP_EMIT: begin
               if (emit_more) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pend_data_ff;
                     rsp_last_in  = pend_last_ff;
                     rsp_user_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_data_in  = {avg_ff, coef_ff,
                                   rlzz_pkg::POS_OUT_W'(col_ff),
                                   rlzz_pkg::POS_OUT_W'(row_ff)};
                  pend_last_in  = (scan_ff == SCAN_W'(COUNT - 1));
                  run_left_in   = run_left_ff - RUN_W'(1);
                  scan_in       = scan_ff + SCAN_W'(1);
                  if (going_up) begin
                     if (col_ff == POS_MAX) begin
                        row_in = row_ff + POS_W'(1);
                     end else if (row_ff == '0) begin
                        col_in = col_ff + POS_W'(1);
                     end else begin
                        row_in = row_ff - POS_W'(1);
                        col_in = col_ff + POS_W'(1);
                     end
                  end else begin
                     if (row_ff == POS_MAX) begin
                        col_in = col_ff + POS_W'(1);
                     end else if (col_ff == '0) begin
                        row_in = row_ff + POS_W'(1);
                     end else begin
                        row_in = row_ff + POS_W'(1);
                        col_in = col_ff - POS_W'(1);
                     end
                  end
               end else if (scan_ff >= SCAN_W'(COUNT)) begin
                  scan_in  = '0;
                  phase_in = PH_AVERAGE;
               end else begin
                  phase_in = PH_SIGN;
               end
            end
            default: begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = pend_data_ff;
                  rsp_last_in   = pend_last_ff;
                  rsp_user_in   = 1'b1;
                  pend_valid_in = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_AVERAGE;
         bits_ff       <= '0;
         left_ff       <= '0;
         run_len_ff    <= '0;
         run_left_ff   <= '0;
         scan_ff       <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bits_ff       <= bits_in;
         left_ff       <= left_in;
         run_len_ff    <= run_len_in;
         run_left_ff   <= run_left_in;
         scan_ff       <= scan_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff     <= shift_in;
      field_ff     <= field_in;
      sign_ff      <= sign_in;
      coef_ff      <= coef_in;
      avg_ff       <= avg_in;
      pend_data_ff <= pend_data_in;
      pend_last_ff <= pend_last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign req_tready = (ctrl.op == rlzz_pkg::OP_FETCH);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rlzz_pkg::RSP_DATA_W'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== hdl/rlzz_checker.sv =====
// port-level checker for the run-length zigzag decoder and its bind
module rlzz_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rlzz_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tuser
);

   // no result straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // block end skips the rest of the byte, so it closes the burst
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("block end not last of burst");

   // padding above the packed fields stays clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[rlzz_pkg::RSP_DATA_W-1:rlzz_pkg::PAYLOAD_W] == '0)
      else $error("result padding not zero");

endmodule

bind run_length_zigzag_block_decoder rlzz_checker u_rlzz_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/testbench.sv =====
// testbench for the run-length zigzag block decoder: table-driven and random byte streams
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BYTE_W        = rlzz_pkg::BYTE_W;
   localparam int POS_OUT_W     = rlzz_pkg::POS_OUT_W;
   localparam int COEF_W        = rlzz_pkg::COEF_W;
   localparam int AVG_W         = rlzz_pkg::AVG_W;
   localparam int PAYLOAD_W     = rlzz_pkg::PAYLOAD_W;
   localparam int RSP_DATA_W    = rlzz_pkg::RSP_DATA_W;
   localparam int SIDE          = rlzz_pkg::DEF_BLOCK_SIDE;
   localparam int CELLS         = SIDE * SIDE;
   localparam int CNT_BITS      = rlzz_pkg::DEF_COUNT_BITS;
   localparam int MAG_BITS      = rlzz_pkg::DEF_MAGNITUDE_BITS;
   localparam int COL_LSB       = POS_OUT_W;
   localparam int COEF_LSB      = 2 * POS_OUT_W;
   localparam int AVG_LSB       = COEF_LSB + COEF_W;
   localparam int DIRECTED_ROWS = 16;
   localparam int RANDOM_ITEMS  = 190;
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_AFTER    = 200;
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_CYCLES   = 40;

   typedef enum logic [1:0] {
      WANT_AVERAGE,
      WANT_SIGN,
      WANT_COUNT,
      WANT_MAGNITUDE
   } parse_phase_type;

   typedef struct {
      parse_phase_type   phase;
      int                bits_left;
      logic [15:0]       shift;
      logic              sign;
      int                run_len;
      int                scan_pos;
      logic [AVG_W-1:0]  average;
   } parse_state_type;

   typedef struct packed {
      logic [POS_OUT_W-1:0] row;
      logic [POS_OUT_W-1:0] col;
      logic [COEF_W-1:0]    coef;
      logic [AVG_W-1:0]     average;
      logic                 last_in_block;
      logic                 last_of_burst;
   } coeff_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              typed;
      logic              typed_hit;
      coeff_type         hit;
   } stream_row_type;

   localparam coeff_type NO_HIT = '0;

   // typed rows carry their own expectation, the others go through the predictor
   localparam stream_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'hA5, 1'b1, 1'b0, NO_HIT},
      '{8'h01, 1'b1, 1'b0, NO_HIT},
      '{8'hFF, 1'b1, 1'b0, NO_HIT},
      '{8'hC0, 1'b1, 1'b1, '{3'd0, 3'd0, 11'h3FF, 8'hA5, 1'b0, 1'b1}},
      '{8'h00, 1'b1, 1'b0, NO_HIT},
      '{8'h3F, 1'b1, 1'b1, '{3'd0, 3'd1, 11'h000, 8'hA5, 1'b0, 1'b1}},
      '{8'h80, 1'b1, 1'b0, NO_HIT},
      '{8'h3F, 1'b0, 1'b0, NO_HIT},
      '{8'h00, 1'b1, 1'b0, NO_HIT},
      '{8'h7E, 1'b1, 1'b0, NO_HIT},
      '{8'hAA, 1'b1, 1'b0, NO_HIT},
      '{8'hFF, 1'b0, 1'b0, NO_HIT},
      '{8'hFF, 1'b1, 1'b0, NO_HIT},
      '{8'h81, 1'b1, 1'b0, NO_HIT},
      '{8'hFF, 1'b1, 1'b0, NO_HIT},
      '{8'h80, 1'b1, 1'b1, '{3'd0, 3'd0, 11'h401, 8'hFF, 1'b0, 1'b1}}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata;   // stream_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // row, column, coefficient, block_average
   logic                  rsp_tlast;   // last_in_block
   logic                  rsp_tuser;   // last_of_burst

   stream_row_type  stream_bytes [$];
   coeff_type       pending_coeffs [$];
   parse_state_type gen_state;
   parse_state_type chk_state;
   int              accepted = 0;
   int              received = 0;
   int              errors = 0;

   run_length_zigzag_block_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic parse_state_type idle_state();
      parse_state_type st;
      st.phase     = WANT_AVERAGE;
      st.bits_left = 0;
      st.shift     = '0;
      st.sign      = 1'b0;
      st.run_len   = 0;
      st.scan_pos  = 0;
      st.average   = '0;
      return st;
   endfunction

   // walk the zigzag scan k steps from the top-left corner
   function automatic logic [2*POS_OUT_W-1:0] zigzag_cell(input int k);
      int r;
      int c;
      int i;
      r = 0;
      c = 0;
      for (i = 0; i < k; i++) begin
         if ((r + c) % 2 == 0) begin
            if (c == SIDE - 1) r++;
            else if (r == 0) c++;
            else begin
               r--;
               c++;
            end
         end else begin
            if (r == SIDE - 1) c++;
            else if (c == 0) r++;
            else begin
               r++;
               c--;
            end
         end
      end
      return {r[POS_OUT_W-1:0], c[POS_OUT_W-1:0]};
   endfunction

   function automatic void decode_byte(inout parse_state_type st, input logic [BYTE_W-1:0] b,
                                       input bit publish);
      coeff_type              burst [$];
      coeff_type              one;
      logic [COEF_W-1:0]      value;
      logic [2*POS_OUT_W-1:0] rc;
      int                     i;
      int                     k;
      bit                     block_done;
      block_done = 1'b0;
      if (st.phase == WANT_AVERAGE) begin
         st.average  = b;
         st.scan_pos = 0;
         st.phase    = WANT_SIGN;
      end else begin
         for (i = BYTE_W - 1; i >= 0 && !block_done; i--) begin
            case (st.phase)
               WANT_SIGN: begin
                  st.sign      = b[i];
                  st.bits_left = CNT_BITS;
                  st.shift     = '0;
                  st.phase     = WANT_COUNT;
               end
               WANT_COUNT: begin
                  st.shift = {st.shift[14:0], b[i]};
                  st.bits_left--;
                  if (st.bits_left == 0) begin
                     st.run_len   = int'(st.shift) + 1;
                     st.bits_left = MAG_BITS;
                     st.shift     = '0;
                     st.phase     = WANT_MAGNITUDE;
                  end
               end
               default: begin
                  st.shift = {st.shift[14:0], b[i]};
                  st.bits_left--;
                  if (st.bits_left == 0) begin
                     value = st.shift[COEF_W-1:0];
                     if (st.sign) value = -value;
                     // overshoot past the block end is dropped
                     for (k = 0; k < st.run_len && st.scan_pos < CELLS; k++) begin
                        rc = zigzag_cell(st.scan_pos);
                        one.row           = rc[2*POS_OUT_W-1:POS_OUT_W];
                        one.col           = rc[POS_OUT_W-1:0];
                        one.coef          = value;
                        one.average       = st.average;
                        one.last_in_block = (st.scan_pos == CELLS - 1);
                        one.last_of_burst = 1'b0;
                        burst.push_back(one);
                        st.scan_pos++;
                     end
                     st.shift = '0;
                     if (st.scan_pos >= CELLS) begin
                        st.scan_pos = 0;
                        st.phase    = WANT_AVERAGE;
                        block_done  = 1'b1;
                     end else begin
                        st.phase = WANT_SIGN;
                     end
                  end
               end
            endcase
         end
      end
      if (publish) begin
         for (k = 0; k < burst.size(); k++) begin
            one = burst[k];
            one.last_of_burst = (k == burst.size() - 1);
            pending_coeffs.push_back(one);
         end
      end
   endfunction

   function automatic void queue_byte(input logic [BYTE_W-1:0] b);
      stream_row_type s;
      s.data      = b;
      s.typed     = 1'b0;
      s.typed_hit = 1'b0;
      s.hit       = NO_HIT;
      stream_bytes.push_back(s);
      decode_byte(gen_state, b, 1'b0);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   initial begin : main_seq
      bit                  bits [$];
      int                  covered;
      int                  len;
      int                  sel;
      int                  k;
      logic [MAG_BITS-1:0] mag;
      logic [CNT_BITS-1:0] cnt;
      logic [BYTE_W-1:0]   acc;
      reset     = 1'b1;
      gen_state = idle_state();
      chk_state = idle_state();
      acc       = '0;
      for (k = 0; k < DIRECTED_ROWS; k++) begin
         stream_bytes.push_back(DIRECTED[k]);
         decode_byte(gen_state, DIRECTED[k].data, 1'b0);
      end
      // mostly whole blocks of random records, with loose noise bytes between
      while (stream_bytes.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
         if (gen_state.phase != WANT_AVERAGE || $urandom_range(0, 7) == 0) begin
            queue_byte(BYTE_W'($urandom_range(0, 255)));
         end else begin
            sel = $urandom_range(0, 3);
            if (sel == 0) queue_byte('0);
            else if (sel == 1) queue_byte('1);
            else queue_byte(BYTE_W'($urandom_range(0, 255)));
            bits.delete();
            covered = 0;
            while (covered < CELLS) begin
               sel = $urandom_range(0, 9);
               if (sel < 5) len = $urandom_range(1, 4);
               else if (sel < 8) len = $urandom_range(1, 16);
               else len = $urandom_range(1, CELLS);
               sel = $urandom_range(0, 7);
               if (sel == 0) mag = '0;
               else if (sel == 1) mag = '1;
               else mag = MAG_BITS'($urandom);
               cnt = CNT_BITS'(len - 1);
               bits.push_back(bit'($urandom_range(0, 1)));
               for (k = CNT_BITS - 1; k >= 0; k--) bits.push_back(cnt[k]);
               for (k = MAG_BITS - 1; k >= 0; k--) bits.push_back(mag[k]);
               covered += len;
            end
            while (bits.size() % BYTE_W != 0) bits.push_back(bit'($urandom_range(0, 1)));
            while (bits.size() != 0) begin
               for (k = 0; k < BYTE_W; k++) acc = {acc[BYTE_W-2:0], bits.pop_front()};
               queue_byte(acc);
            end
         end
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (accepted < stream_bytes.size() || pending_coeffs.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : request_driver
      int i;
      int gap;
      bit steady;
      bit drain;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      steady     = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      for (i = 0; i < stream_bytes.size(); i++) begin
         gap = steady ? 0 : $urandom_range(0, 11);
         if ($urandom_range(0, 15) == 0) steady = !steady;
         drain = (i == DIRECTED_ROWS) || (i == stream_bytes.size() / 2);
         if (gap != 0 || drain) req_tvalid = 1'b0;
         // let every outstanding coefficient drain before going on
         if (drain)
            while (pending_coeffs.size() != 0) @(negedge clock);
         repeat (gap) @(negedge clock);
         req_tvalid = 1'b1;
         req_tdata  = stream_bytes[i].data;
         do @(posedge clock); while (!req_tready);
         @(negedge clock);
      end
      req_tvalid = 1'b0;
   end

   initial begin : result_sink
      int stall;
      bit steady;
      bit held;
      rsp_tready = 1'b0;
      steady     = 1'b0;
      held       = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         // one long hold-off so the decoder backs up onto its request side
         if (!held && received >= HOLD_AFTER) begin
            held       = 1'b1;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = steady ? 0 : $urandom_range(0, 11);
         if ($urandom_range(0, 15) == 0) steady = !steady;
         if (stall != 0) rsp_tready = 1'b0;
         repeat (stall) @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : request_monitor
      if (!reset && req_tvalid && req_tready) begin
         decode_byte(chk_state, stream_bytes[accepted].data, !stream_bytes[accepted].typed);
         if (stream_bytes[accepted].typed && stream_bytes[accepted].typed_hit)
            pending_coeffs.push_back(stream_bytes[accepted].hit);
         accepted++;
      end
   end

   always @(posedge clock) begin : result_monitor
      coeff_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         received++;
         if (pending_coeffs.size() == 0) begin
            $error("result with nothing pending: tdata %h tlast %b tuser %b",
                   rsp_tdata, rsp_tlast, rsp_tuser);
            errors++;
         end else begin
            want = pending_coeffs.pop_front();
            check_field("row", 32'(want.row), 32'(rsp_tdata[COL_LSB-1:0]));
            check_field("column", 32'(want.col), 32'(rsp_tdata[COEF_LSB-1:COL_LSB]));
            check_field("coefficient", 32'(want.coef), 32'(rsp_tdata[AVG_LSB-1:COEF_LSB]));
            check_field("block_average", 32'(want.average),
                        32'(rsp_tdata[PAYLOAD_W-1:AVG_LSB]));
            check_field("tdata_padding", 32'd0, 32'(rsp_tdata[RSP_DATA_W-1:PAYLOAD_W]));
            check_field("last_in_block", 32'(want.last_in_block), 32'(rsp_tlast));
            check_field("last_of_burst", 32'(want.last_of_burst), 32'(rsp_tuser));
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
